// File: rtl/drst_pkg.sv
// ----------------------------------------------------------------------------
// drst_pkg: DMA ring segment tracker package
// Shared types, sizes and controller state encoding.
// ----------------------------------------------------------------------------
package drst_pkg;

    // Receive ring: 128 bytes, index arithmetic is modulo by wrap of RING_W bits
    localparam int RING_SIZE   = 128;
    localparam int RING_W      = $clog2(RING_SIZE);
    // Segment queue: 8 slots, at most 7 segments held
    localparam int QUEUE_SLOTS = 8;
    localparam int QIDX_W      = $clog2(QUEUE_SLOTS);

    localparam logic [7:0] FRAME_LIMIT_RST = 8'd20;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] remaining_count;
    } req_t;

    typedef struct packed {
        logic       seg_valid;
        logic [6:0] seg_pos;
        logic [6:0] seg_len;
        logic [7:0] clipped_len;
        logic [1:0] pushed_count;
        logic [1:0] dropped_count;
        logic [2:0] queue_level;
    } rsp_t;

    typedef struct packed {
        logic [RING_W-1:0] pos;
        logic [RING_W-1:0] len;
    } seg_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PUSH2,
        ST_READ,
        ST_DONE
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // capture request word, clear result
        logic push1;    // first (or only) segment push
        logic push2;    // second segment after a wrap
        logic rd;       // read oldest entry
        logic pop_fin;  // finish pop from read data
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic no_new;
        logic wrap_two;
        logic q_empty;
    } dp_status_t;

endpackage

// File: rtl/dma_ring_segment_tracker.sv
// ----------------------------------------------------------------------------
// dma_ring_segment_tracker: DMA receive ring segment tracker
// Turns DMA remaining counts into (position, length) segments held in a
// seven-deep queue, and pops them with a frame-limited length.
// ----------------------------------------------------------------------------
// Usage: a request word is taken on a clock edge with start high and busy
// low. Exactly one result word follows on rsp, marked by rsp_valid for a
// single cycle; there is no back-pressure, so the receiver must capture it
// then. The sequencer steps an update through evaluate and the strobe,
// with a second push state when the write pointer wraps and two segments
// are pushed, the queue memory having one write port; a pop adds a read
// state for the registered memory read, skipped on an empty queue. busy
// drops the cycle after the strobe. The user must write frame_limit
// through cfg_valid/cfg_ready/cfg_data only while idle; the block itself
// does not enforce this. cfg_ready is always high. A push when the queue
// holds seven segments drops the oldest; dropped_count reports it.
// ----------------------------------------------------------------------------
module dma_ring_segment_tracker (
    input  logic            clk,
    input  logic            rst_n,
    // request
    input  logic            start,
    output logic            busy,
    input  drst_pkg::req_t  req,
    // result
    output logic            rsp_valid,
    output drst_pkg::rsp_t  rsp,
    // frame_limit register write
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_data
);

    drst_pkg::ctrl_cmd_t  cmd;
    drst_pkg::dp_status_t status;
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer
    drst_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (rsp_valid)
    );

    // pointers, queue memory, result registers
    drst_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .status   (status),
        .rsp      (rsp)
    );

endmodule

// File: rtl/drst_ctrl.sv
// ----------------------------------------------------------------------------
// drst_ctrl: sequencer
// Steps each request through evaluate, optional second push or queue read,
// and a one-cycle result strobe.
// ----------------------------------------------------------------------------
module drst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  drst_pkg::dp_status_t  status,
    output drst_pkg::ctrl_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);

    drst_pkg::state_t state_reg;
    drst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drst_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = drst_pkg::ST_EVAL;
                end
            end
            drst_pkg::ST_EVAL:
            begin
                if (status.is_pop)
                begin
                    state_next = status.q_empty ? drst_pkg::ST_DONE : drst_pkg::ST_READ;
                end
                else if (!status.no_new && status.wrap_two)
                begin
                    state_next = drst_pkg::ST_PUSH2;
                end
                else
                begin
                    state_next = drst_pkg::ST_DONE;
                end
            end
            drst_pkg::ST_PUSH2: state_next = drst_pkg::ST_DONE;
            drst_pkg::ST_READ:  state_next = drst_pkg::ST_DONE;
            drst_pkg::ST_DONE:  state_next = drst_pkg::ST_IDLE;
            default:            state_next = drst_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            drst_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            drst_pkg::ST_EVAL:
            begin
                cmd.rd    = status.is_pop && !status.q_empty;
                cmd.push1 = !status.is_pop && !status.no_new;
            end
            drst_pkg::ST_PUSH2: cmd.push2   = 1'b1;
            drst_pkg::ST_READ:  cmd.pop_fin = 1'b1;
            drst_pkg::ST_DONE:  done        = 1'b1;
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/drst_dp.sv
// ----------------------------------------------------------------------------
// drst_dp: datapath
// Write index arithmetic, segment queue memory with head/tail pointers,
// frame-limit register and result registers.
// ----------------------------------------------------------------------------
module drst_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  drst_pkg::req_t        req,
    input  drst_pkg::ctrl_cmd_t   cmd,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_data,
    output drst_pkg::dp_status_t  status,
    output drst_pkg::rsp_t        rsp
);

    localparam int RW = drst_pkg::RING_W;
    localparam int QW = drst_pkg::QIDX_W;

    drst_pkg::seg_entry_t seg_mem [drst_pkg::QUEUE_SLOTS];
    drst_pkg::seg_entry_t rd_data_reg;
    drst_pkg::seg_entry_t wr_data;
    logic                 wr_en;

    logic          opcode_reg,     opcode_next;
    logic [7:0]    remain_reg,     remain_next;
    logic [QW-1:0] head_reg,       head_next;
    logic [QW-1:0] tail_reg,       tail_next;
    logic [RW-1:0] last_reg,       last_next;
    logic [7:0]    frame_lim_reg,  frame_lim_next;
    logic          seg_valid_reg,  seg_valid_next;
    logic [6:0]    seg_pos_reg,    seg_pos_next;
    logic [6:0]    seg_len_reg,    seg_len_next;
    logic [7:0]    clip_reg,       clip_next;
    logic [1:0]    pushed_reg,     pushed_next;
    logic [1:0]    dropped_reg,    dropped_next;

    logic [RW-1:0] cur_idx;
    logic          wrapped;
    logic [RW-1:0] len1;
    logic [QW-1:0] head_inc;
    logic          q_full;
    logic [7:0]    rd_len_ext;

    // cur = (RING_SIZE - remaining mod RING_SIZE) mod RING_SIZE, i.e. a negate
    assign cur_idx  = RW'(0) - remain_reg[RW-1:0];
    assign wrapped  = cur_idx < last_reg;
    // wrap: RING_SIZE - last, otherwise cur - last (both modulo ring)
    assign len1     = (wrapped ? RW'(0) : cur_idx) - last_reg;
    assign head_inc = head_reg + QW'(1);
    assign q_full   = head_inc == tail_reg;
    assign rd_len_ext = 8'(rd_data_reg.len);

    assign status.is_pop   = opcode_reg == drst_pkg::OP_POP;
    assign status.no_new   = cur_idx == last_reg;
    assign status.wrap_two = wrapped && (cur_idx != RW'(0));
    assign status.q_empty  = head_reg == tail_reg;

    assign wr_en = cmd.push1 || cmd.push2;
    always_comb
    begin
        if (cmd.push2)
        begin
            wr_data.pos = RW'(0);
            wr_data.len = cur_idx;
        end
        else
        begin
            wr_data.pos = last_reg;
            wr_data.len = len1;
        end
    end

    always_comb
    begin
        opcode_next    = opcode_reg;
        remain_next    = remain_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        last_next      = last_reg;
        frame_lim_next = cfg_we ? cfg_data : frame_lim_reg;
        seg_valid_next = seg_valid_reg;
        seg_pos_next   = seg_pos_reg;
        seg_len_next   = seg_len_reg;
        clip_next      = clip_reg;
        pushed_next    = pushed_reg;
        dropped_next   = dropped_reg;

        if (cmd.load)
        begin
            opcode_next    = req.opcode;
            remain_next    = req.remaining_count;
            seg_valid_next = 1'b0;
            seg_pos_next   = '0;
            seg_len_next   = '0;
            clip_next      = '0;
            pushed_next    = '0;
            dropped_next   = '0;
        end

        if (wr_en)
        begin
            // full queue: oldest entry is dropped
            head_next = head_inc;
            if (q_full)
            begin
                tail_next    = tail_reg + QW'(1);
                dropped_next = dropped_reg + 2'd1;
            end
            pushed_next = cmd.push2 ? 2'd2 : 2'd1;
        end

        if (cmd.push1)
        begin
            last_next = cur_idx;
        end

        if (cmd.pop_fin)
        begin
            seg_valid_next = 1'b1;
            seg_pos_next   = 7'(rd_data_reg.pos);
            seg_len_next   = 7'(rd_data_reg.len);
            clip_next      = (rd_len_ext > frame_lim_reg) ? frame_lim_reg : rd_len_ext;
            tail_next      = tail_reg + QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            last_reg      <= '0;
            frame_lim_reg <= drst_pkg::FRAME_LIMIT_RST;
            opcode_reg    <= drst_pkg::OP_UPDATE;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            last_reg      <= last_next;
            frame_lim_reg <= frame_lim_next;
            opcode_reg    <= opcode_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        remain_reg    <= remain_next;
        seg_valid_reg <= seg_valid_next;
        seg_pos_reg   <= seg_pos_next;
        seg_len_reg   <= seg_len_next;
        clip_reg      <= clip_next;
        pushed_reg    <= pushed_next;
        dropped_reg   <= dropped_next;
    end

    // segment queue memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seg_mem[head_reg] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= seg_mem[tail_reg];
        end
    end

    assign rsp.seg_valid     = seg_valid_reg;
    assign rsp.seg_pos       = seg_pos_reg;
    assign rsp.seg_len       = seg_len_reg;
    assign rsp.clipped_len   = clip_reg;
    assign rsp.pushed_count  = pushed_reg;
    assign rsp.dropped_count = dropped_reg;
    assign rsp.queue_level   = 3'(head_reg - tail_reg);

    a_push_adv: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> head_reg == $past(head_inc))
        else $error("head pointer did not advance on push");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> head_reg != tail_reg)
        else $error("queue empty straight after a push");

    a_push2_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push2 |-> $past(cmd.push1))
        else $error("second push without first push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd || cmd.pop_fin) |-> head_reg != tail_reg)
        else $error("queue read while empty");

endmodule
